FILE: hw/rtl/pnorm_pkg.sv
// Shared types and constants for the path normalizer.
// Used by the interfaces, controller, datapath, output buffer and top level.
package pnorm_pkg;

    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int RIDX_W   = 12;
    localparam int STATUS_W = 3;
    localparam int OLEN_W   = 13;
    localparam int CFG_W    = 13;

    typedef logic [CMD_W-1:0]    cmd_code_t;
    typedef logic [STATUS_W-1:0] status_code_t;

    localparam cmd_code_t CMD_BEGIN = 2'd0;
    localparam cmd_code_t CMD_BYTE  = 2'd1;
    localparam cmd_code_t CMD_END   = 2'd2;
    localparam cmd_code_t CMD_READ  = 2'd3;

    localparam status_code_t RS_ACCEPT   = 3'd0;
    localparam status_code_t RS_OK       = 3'd1;
    localparam status_code_t RS_LONG     = 3'd2;
    localparam status_code_t RS_REL      = 3'd3;
    localparam status_code_t RS_SMALL    = 3'd4;
    localparam status_code_t RS_NOTREADY = 3'd5;

    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;

    localparam logic [CFG_W-1:0] MAX_OUT_LEN_RESET = 13'd4096;

    // Life cycle of one path, kept by the datapath.
    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_COLLECT = 4'b0010,
        PH_DONE    = 4'b0100,
        PH_ERROR   = 4'b1000
    } phase_t;

    // What an incoming request needs beyond the cycle in which it is taken.
    typedef enum logic [2:0] {
        CLS_IMM,
        CLS_IMM_POP,
        CLS_FIN_NOW,
        CLS_FIN_POP,
        CLS_READ
    } req_class_t;

    typedef struct packed {
        logic take;
        logic pop_load;
        logic finish;
        logic read_out;
    } ctrl_cmd_t;

    typedef struct packed {
        status_code_t        status;
        logic [OLEN_W-1:0]   out_length;
        logic [BYTE_W-1:0]   out_byte;
    } result_t;

endpackage

FILE: hw/rtl/pnorm_if.sv
// Request and response channel interfaces of the path normalizer.
// Depends on pnorm_pkg for field widths.
interface pnorm_req_if;
    logic                          valid;
    logic                          ready;
    pnorm_pkg::cmd_code_t          cmd;
    logic [pnorm_pkg::BYTE_W-1:0]  path_byte;
    logic [pnorm_pkg::RIDX_W-1:0]  read_index;

    modport source (output valid, cmd, path_byte, read_index, input ready);
    modport sink   (input valid, cmd, path_byte, read_index, output ready);
endinterface

interface pnorm_rsp_if;
    logic                          valid;
    logic                          ready;
    pnorm_pkg::status_code_t       status;
    logic [pnorm_pkg::OLEN_W-1:0]  out_length;
    logic [pnorm_pkg::BYTE_W-1:0]  out_byte;

    modport source (output valid, status, out_length, out_byte, input ready);
    modport sink   (input valid, status, out_length, out_byte, output ready);
endinterface

FILE: hw/rtl/path_normalizer_unit.sv
// Path normalizer: takes an absolute path one byte per request (begin, bytes,
// end) and builds its normalized form, dropping empty and dot segments and
// undoing the last kept segment on each dot-dot; the result is then read back
// one byte per request by index. Begin, path bytes and failed requests are
// done in the cycle they are taken; a slash that closes a dot-dot segment
// with a kept segment left to drop also passes through ST_POP, as the
// previous length comes back through the registered read port of the slash
// stack memory; end passes through ST_FIN, after ST_POP_FIN when it drops a
// segment in that way, and a read through ST_READ, for the registered read
// port of the result memory. Each response is registered in a two-entry
// output buffer, so a stalled response does not stop the next request from
// being taken. No memory needs clearing after reset. The capacity register
// (reset 4096) may only be written while the block is idle.
module path_normalizer_unit #(
    parameter int PATH_CAP = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    pnorm_req_if.sink                   req,
    pnorm_rsp_if.source                 rsp,
    input  logic                        cfg_we,
    input  logic [pnorm_pkg::CFG_W-1:0] cfg_wdata
);

    pnorm_pkg::ctrl_cmd_t  ctrl;
    pnorm_pkg::req_class_t req_class;
    pnorm_pkg::result_t    push_data;
    logic                  push;
    logic                  obuf_full;
    logic                  req_ready;

    assign req.ready = req_ready;

    pnorm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .obuf_full (obuf_full),
        .req_class (req_class),
        .ctrl      (ctrl)
    );

    pnorm_dp #(
        .PATH_CAP (PATH_CAP)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (req.cmd),
        .path_byte  (req.path_byte),
        .read_index (req.read_index),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .ctrl       (ctrl),
        .req_class  (req_class),
        .push       (push),
        .push_data  (push_data)
    );

    pnorm_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (obuf_full),
        .rsp       (rsp)
    );

endmodule

FILE: hw/rtl/pnorm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pnorm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/pnorm_ctrl.sv
// Sequencing controller of the path normalizer.
// Depends on pnorm_pkg; drives the datapath through ctrl_cmd_t.
module pnorm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic                  obuf_full,
    input  pnorm_pkg::req_class_t req_class,
    output pnorm_pkg::ctrl_cmd_t  ctrl
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_POP     = 5'b00010,
        ST_POP_FIN = 5'b00100,
        ST_FIN     = 5'b01000,
        ST_READ    = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take;

    // A free slot in the output buffer is kept at every take, so a request
    // that answers later always finds room when it completes.
    assign req_ready = (state_reg == ST_IDLE) && !obuf_full;
    assign take      = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (req_class)
                        pnorm_pkg::CLS_IMM_POP: state_next = ST_POP;
                        pnorm_pkg::CLS_FIN_POP: state_next = ST_POP_FIN;
                        pnorm_pkg::CLS_FIN_NOW: state_next = ST_FIN;
                        pnorm_pkg::CLS_READ:    state_next = ST_READ;
                        default:                state_next = ST_IDLE;
                    endcase
                end
            end
            ST_POP:     state_next = ST_IDLE;
            ST_POP_FIN: state_next = ST_FIN;
            ST_FIN:     state_next = ST_IDLE;
            ST_READ:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctrl.take     = take;
        ctrl.pop_load = (state_reg == ST_POP) || (state_reg == ST_POP_FIN);
        ctrl.finish   = (state_reg == ST_FIN);
        ctrl.read_out = (state_reg == ST_READ);
    end

endmodule

FILE: hw/rtl/pnorm_obuf.sv
// Two-entry output buffer that decouples the response channel from the core.
// Depends on pnorm_pkg and pnorm_rsp_if.
module pnorm_obuf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pnorm_pkg::result_t push_data,
    output logic               full,
    pnorm_rsp_if.source        rsp
);

    logic               valid0_reg;
    logic               valid0_next;
    logic               valid1_reg;
    logic               valid1_next;
    pnorm_pkg::result_t data0_reg;
    pnorm_pkg::result_t data0_next;
    pnorm_pkg::result_t data1_reg;
    pnorm_pkg::result_t data1_next;
    logic               pop;

    assign pop = valid0_reg && rsp.ready;

    always_comb
    begin
        valid0_next = valid0_reg;
        valid1_next = valid1_reg;
        data0_next  = data0_reg;
        data1_next  = data1_reg;
        if (pop)
        begin
            if (valid1_reg)
            begin
                data0_next  = data1_reg;
                valid1_next = push;
                data1_next  = push_data;
            end
            else
            begin
                valid0_next = push;
                data0_next  = push_data;
            end
        end
        else if (!valid0_reg)
        begin
            valid0_next = push;
            data0_next  = push_data;
        end
        else if (!valid1_reg)
        begin
            valid1_next = push;
            data1_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
            valid1_reg <= 1'b0;
        end
        else
        begin
            valid0_reg <= valid0_next;
            valid1_reg <= valid1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data0_reg <= data0_next;
        data1_reg <= data1_next;
    end

    assign full           = valid1_reg;
    assign rsp.valid      = valid0_reg;
    assign rsp.status     = data0_reg.status;
    assign rsp.out_length = data0_reg.out_length;
    assign rsp.out_byte   = data0_reg.out_byte;

    // A response pushed into a full buffer with nothing leaving would be lost.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && valid1_reg && !pop))
        else $error("output buffer overflow");

endmodule

FILE: hw/rtl/pnorm_dp.sv
// Datapath of the path normalizer: path state, slash stack and result memory.
// Depends on pnorm_pkg and pnorm_ram; sequenced by pnorm_ctrl.
module pnorm_dp #(
    parameter int PATH_CAP = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pnorm_pkg::cmd_code_t            cmd,
    input  logic [pnorm_pkg::BYTE_W-1:0]    path_byte,
    input  logic [pnorm_pkg::RIDX_W-1:0]    read_index,
    input  logic                            cfg_we,
    input  logic [pnorm_pkg::CFG_W-1:0]     cfg_wdata,
    input  pnorm_pkg::ctrl_cmd_t            ctrl,
    output pnorm_pkg::req_class_t           req_class,
    output logic                            push,
    output pnorm_pkg::result_t              push_data
);

    localparam int LEN_W     = $clog2(PATH_CAP + 1);
    localparam int ADDR_W    = $clog2(PATH_CAP);
    localparam int STK_DEPTH = PATH_CAP / 2;
    localparam int STK_AW    = $clog2(STK_DEPTH);
    localparam int SC_W      = $clog2(STK_DEPTH + 1);

    pnorm_pkg::phase_t phase_reg;
    pnorm_pkg::phase_t phase_next;
    logic [SC_W-1:0]   stack_count_reg;
    logic [SC_W-1:0]   stack_count_next;
    logic [LEN_W-1:0]  result_len_reg;
    logic [LEN_W-1:0]  result_len_next;
    logic [LEN_W-1:0]  seg_len_reg;
    logic [LEN_W-1:0]  seg_len_next;
    logic [pnorm_pkg::BYTE_W-1:0] seg_b0_reg;
    logic [pnorm_pkg::BYTE_W-1:0] seg_b0_next;
    logic [pnorm_pkg::BYTE_W-1:0] seg_b1_reg;
    logic [pnorm_pkg::BYTE_W-1:0] seg_b1_next;
    logic [LEN_W-1:0]  src_count_reg;
    logic [LEN_W-1:0]  src_count_next;
    logic              too_long_reg;
    logic              too_long_next;
    logic              relative_reg;
    logic              relative_next;
    logic              term_reg;
    logic              term_next;
    logic [pnorm_pkg::RIDX_W-1:0] ridx_reg;
    logic [pnorm_pkg::RIDX_W-1:0] ridx_next;
    logic [pnorm_pkg::CFG_W-1:0]  max_out_len_reg;

    logic              collecting;
    logic              done;
    logic              seg_empty;
    logic              seg_dot;
    logic              seg_dotdot;
    logic              keep_seg;
    logic              pop_needed;
    logic              byte_live;
    logic [LEN_W-1:0]  src_inc;
    logic              hits_cap;
    logic              rel_now;
    logic              byte_proc;
    logic              byte_slash;
    logic              byte_char;
    logic              end_ok;
    logic              end_proc;
    logic              close_seg;
    logic [LEN_W-1:0]  close_len;
    logic [LEN_W-1:0]  char_pos;
    logic [LEN_W-1:0]  len_plus1;
    logic [LEN_W-1:0]  fin_len;
    logic [LEN_W-1:0]  fin_total;
    logic              fin_ok;
    logic [SC_W-1:0]   stack_top;
    pnorm_pkg::status_code_t imm_status;

    logic                         store_we;
    logic [ADDR_W-1:0]            store_waddr;
    logic [pnorm_pkg::BYTE_W-1:0] store_wdata;
    logic                         store_re;
    logic [pnorm_pkg::BYTE_W-1:0] store_rdata;
    logic                         stk_we;
    logic                         stk_re;
    logic [ADDR_W-1:0]            stk_rdata;

    assign collecting = (phase_reg == pnorm_pkg::PH_COLLECT);
    assign done       = (phase_reg == pnorm_pkg::PH_DONE);

    // Only the first two bytes of an open segment are kept; that is enough
    // to recognise the dot and dot-dot segments.
    assign seg_empty  = (seg_len_reg == '0);
    assign seg_dot    = (seg_len_reg == LEN_W'(1)) && (seg_b0_reg == pnorm_pkg::CHAR_DOT);
    assign seg_dotdot = (seg_len_reg == LEN_W'(2)) && (seg_b0_reg == pnorm_pkg::CHAR_DOT)
                        && (seg_b1_reg == pnorm_pkg::CHAR_DOT);
    assign keep_seg   = !seg_empty && !seg_dot && !seg_dotdot;
    assign pop_needed = seg_dotdot && (stack_count_reg != '0);

    assign byte_live  = collecting && !too_long_reg && !term_reg;
    assign src_inc    = src_count_reg + LEN_W'(1);
    assign hits_cap   = (src_inc >= LEN_W'(PATH_CAP));
    assign rel_now    = relative_reg
                        || ((src_count_reg == '0) && (path_byte != pnorm_pkg::CHAR_SLASH));
    assign byte_proc  = (cmd == pnorm_pkg::CMD_BYTE) && byte_live
                        && (path_byte != pnorm_pkg::CHAR_NUL) && !hits_cap && !rel_now;
    assign byte_slash = byte_proc && (path_byte == pnorm_pkg::CHAR_SLASH);
    assign byte_char  = byte_proc && (path_byte != pnorm_pkg::CHAR_SLASH);

    assign end_ok     = (max_out_len_reg != '0) && !too_long_reg && !relative_reg
                        && (src_count_reg != '0);
    assign end_proc   = (cmd == pnorm_pkg::CMD_END) && collecting && end_ok;
    assign close_seg  = ctrl.take && (byte_slash || end_proc);

    assign close_len  = result_len_reg + LEN_W'(1) + seg_len_reg;
    assign char_pos   = result_len_reg + LEN_W'(1) + seg_len_reg;
    assign len_plus1  = result_len_reg + LEN_W'(1);
    assign fin_len    = (result_len_reg == '0) ? LEN_W'(1) : result_len_reg;
    assign fin_total  = fin_len + LEN_W'(1);
    assign fin_ok     = (fin_total <= max_out_len_reg);
    assign stack_top  = stack_count_reg - SC_W'(1);

    always_comb
    begin
        case (cmd)
            pnorm_pkg::CMD_BYTE:
                req_class = (byte_slash && pop_needed) ? pnorm_pkg::CLS_IMM_POP
                                                       : pnorm_pkg::CLS_IMM;
            pnorm_pkg::CMD_END:
                if (end_proc)
                begin
                    req_class = pop_needed ? pnorm_pkg::CLS_FIN_POP : pnorm_pkg::CLS_FIN_NOW;
                end
                else
                begin
                    req_class = pnorm_pkg::CLS_IMM;
                end
            pnorm_pkg::CMD_READ:
                req_class = done ? pnorm_pkg::CLS_READ : pnorm_pkg::CLS_IMM;
            default:
                req_class = pnorm_pkg::CLS_IMM;
        endcase
    end

    always_comb
    begin
        case (cmd)
            pnorm_pkg::CMD_BEGIN:
                imm_status = pnorm_pkg::RS_ACCEPT;
            pnorm_pkg::CMD_BYTE:
                imm_status = collecting ? pnorm_pkg::RS_ACCEPT : pnorm_pkg::RS_NOTREADY;
            pnorm_pkg::CMD_END:
                if (!collecting)
                begin
                    imm_status = pnorm_pkg::RS_NOTREADY;
                end
                else if (max_out_len_reg == '0)
                begin
                    imm_status = pnorm_pkg::RS_SMALL;
                end
                else if (too_long_reg)
                begin
                    imm_status = pnorm_pkg::RS_LONG;
                end
                else
                begin
                    imm_status = pnorm_pkg::RS_REL;
                end
            default:
                imm_status = pnorm_pkg::RS_NOTREADY;
        endcase
    end

    always_comb
    begin
        push_data.status     = imm_status;
        push_data.out_length = '0;
        push_data.out_byte   = '0;
        if (ctrl.finish)
        begin
            push_data.status     = fin_ok ? pnorm_pkg::RS_OK : pnorm_pkg::RS_SMALL;
            push_data.out_length = fin_ok ? pnorm_pkg::OLEN_W'(fin_total) : '0;
        end
        else if (ctrl.read_out)
        begin
            push_data.status     = pnorm_pkg::RS_OK;
            push_data.out_length = pnorm_pkg::OLEN_W'(len_plus1);
            // Positions at or past the length, the terminator included, read as NUL.
            push_data.out_byte   = (ridx_reg < result_len_reg) ? store_rdata : '0;
        end
    end

    assign push = (ctrl.take && ((req_class == pnorm_pkg::CLS_IMM)
                                 || (req_class == pnorm_pkg::CLS_IMM_POP)))
                  || ctrl.finish || ctrl.read_out;

    always_comb
    begin
        phase_next       = phase_reg;
        stack_count_next = stack_count_reg;
        result_len_next  = result_len_reg;
        seg_len_next     = seg_len_reg;
        seg_b0_next      = seg_b0_reg;
        seg_b1_next      = seg_b1_reg;
        src_count_next   = src_count_reg;
        too_long_next    = too_long_reg;
        relative_next    = relative_reg;
        term_next        = term_reg;
        ridx_next        = ridx_reg;
        if (ctrl.take)
        begin
            case (cmd)
                pnorm_pkg::CMD_BEGIN:
                begin
                    phase_next       = pnorm_pkg::PH_COLLECT;
                    stack_count_next = '0;
                    result_len_next  = '0;
                    seg_len_next     = '0;
                    seg_b0_next      = '0;
                    seg_b1_next      = '0;
                    src_count_next   = '0;
                    too_long_next    = 1'b0;
                    relative_next    = 1'b0;
                    term_next        = 1'b0;
                end
                pnorm_pkg::CMD_BYTE:
                begin
                    if (byte_live)
                    begin
                        if (path_byte == pnorm_pkg::CHAR_NUL)
                        begin
                            term_next = 1'b1;
                        end
                        else
                        begin
                            src_count_next = src_inc;
                            if (hits_cap)
                            begin
                                too_long_next = 1'b1;
                            end
                            else
                            begin
                                relative_next = rel_now;
                                if (byte_char)
                                begin
                                    if (seg_len_reg == '0)
                                    begin
                                        seg_b0_next = path_byte;
                                    end
                                    else if (seg_len_reg == LEN_W'(1))
                                    begin
                                        seg_b1_next = path_byte;
                                    end
                                    seg_len_next = seg_len_reg + LEN_W'(1);
                                end
                            end
                        end
                    end
                end
                pnorm_pkg::CMD_END:
                begin
                    if (collecting && !end_ok)
                    begin
                        phase_next = pnorm_pkg::PH_ERROR;
                    end
                end
                default:
                begin
                    if (done)
                    begin
                        ridx_next = read_index;
                    end
                end
            endcase

            if (close_seg)
            begin
                seg_len_next = '0;
                seg_b0_next  = '0;
                seg_b1_next  = '0;
                if (pop_needed)
                begin
                    stack_count_next = stack_top;
                end
                else if (keep_seg)
                begin
                    if (stack_count_reg < SC_W'(STK_DEPTH))
                    begin
                        stack_count_next = stack_count_reg + SC_W'(1);
                    end
                    result_len_next = close_len;
                end
            end
        end

        // The length before the dropped segment arrives from the stack in the cycle after its read.
        if (ctrl.pop_load)
        begin
            result_len_next = LEN_W'(stk_rdata);
        end

        if (ctrl.finish)
        begin
            if (result_len_reg == '0)
            begin
                result_len_next = LEN_W'(1);
            end
            phase_next = fin_ok ? pnorm_pkg::PH_DONE : pnorm_pkg::PH_ERROR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= pnorm_pkg::PH_IDLE;
            stack_count_reg <= '0;
            result_len_reg  <= '0;
            seg_len_reg     <= '0;
            seg_b0_reg      <= '0;
            seg_b1_reg      <= '0;
            src_count_reg   <= '0;
            too_long_reg    <= 1'b0;
            relative_reg    <= 1'b0;
            term_reg        <= 1'b0;
            max_out_len_reg <= pnorm_pkg::MAX_OUT_LEN_RESET;
        end
        else
        begin
            phase_reg       <= phase_next;
            stack_count_reg <= stack_count_next;
            result_len_reg  <= result_len_next;
            seg_len_reg     <= seg_len_next;
            seg_b0_reg      <= seg_b0_next;
            seg_b1_reg      <= seg_b1_next;
            src_count_reg   <= src_count_next;
            too_long_reg    <= too_long_next;
            relative_reg    <= relative_next;
            term_reg        <= term_next;
            if (cfg_we)
            begin
                max_out_len_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg <= ridx_next;
    end

    // Result memory: segment bytes and separating slashes go in as the path
    // arrives; the lone slash of an empty result is written at the end.
    always_comb
    begin
        store_we    = 1'b0;
        store_waddr = ADDR_W'(char_pos);
        store_wdata = path_byte;
        if (ctrl.take && byte_char)
        begin
            store_we = 1'b1;
        end
        else if (close_seg && keep_seg)
        begin
            store_we    = 1'b1;
            store_waddr = ADDR_W'(result_len_reg);
            store_wdata = pnorm_pkg::CHAR_SLASH;
        end
        else if (ctrl.finish && (result_len_reg == '0))
        begin
            store_we    = 1'b1;
            store_waddr = '0;
            store_wdata = pnorm_pkg::CHAR_SLASH;
        end
    end

    assign store_re = ctrl.take && (cmd == pnorm_pkg::CMD_READ) && done;

    pnorm_ram #(
        .WIDTH (pnorm_pkg::BYTE_W),
        .DEPTH (PATH_CAP)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .re    (store_re),
        .raddr (ADDR_W'(read_index)),
        .rdata (store_rdata)
    );

    assign stk_we = close_seg && keep_seg && (stack_count_reg < SC_W'(STK_DEPTH));
    assign stk_re = close_seg && pop_needed;

    pnorm_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (STK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stack_count_reg[STK_AW-1:0]),
        .wdata (ADDR_W'(result_len_reg)),
        .re    (stk_re),
        .raddr (stack_top[STK_AW-1:0]),
        .rdata (stk_rdata)
    );

    // Every kept byte and slash came from a source byte.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_len_reg <= src_count_reg)
        else $error("result length exceeds source length");

    // Each stacked segment used at least a slash and one character.
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {stack_count_reg, 1'b0} <= src_count_reg)
        else $error("slash stack deeper than the source allows");

    a_pop_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop_load |-> $past(stk_re))
        else $error("stack load without a preceding stack read");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for path_normalizer_unit: queued requests, random idling on both channels.
// Depends on pnorm_pkg and the request and response interfaces in pnorm_if.sv.
module testbench;

    localparam int PATH_CAP      = 4096;
    localparam int STACK_DEPTH   = PATH_CAP / 2;
    localparam int RANDOM_ITEMS  = 330;
    localparam int DRAIN_SETTLE  = 6;
    localparam int TAIL_CYCLES   = 10;
    localparam int STALL_LIMIT   = 1000;

    typedef enum logic [1:0] {
        STEP_REQ,
        STEP_CFG,
        STEP_DRAIN
    } step_kind_t;

    typedef struct {
        step_kind_t                   kind;
        pnorm_pkg::cmd_code_t         cmd;
        logic [pnorm_pkg::BYTE_W-1:0] pbyte;
        logic [pnorm_pkg::RIDX_W-1:0] ridx;
        logic [pnorm_pkg::CFG_W-1:0]  cap;
    } plan_step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                         req_valid = 1'b0;
    pnorm_pkg::cmd_code_t         req_cmd   = pnorm_pkg::CMD_BEGIN;
    logic [pnorm_pkg::BYTE_W-1:0] req_byte  = '0;
    logic [pnorm_pkg::RIDX_W-1:0] req_index = '0;
    logic                         rsp_ready = 1'b0;
    logic                         cfg_we    = 1'b0;
    logic [pnorm_pkg::CFG_W-1:0]  cfg_wdata = pnorm_pkg::MAX_OUT_LEN_RESET;

    pnorm_req_if req_ch();
    pnorm_rsp_if rsp_ch();

    assign req_ch.valid      = req_valid;
    assign req_ch.cmd        = req_cmd;
    assign req_ch.path_byte  = req_byte;
    assign req_ch.read_index = req_index;
    assign rsp_ch.ready      = rsp_ready;

    path_normalizer_unit #(
        .PATH_CAP (PATH_CAP)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Requests still to be driven, and the responses they are owed.
    plan_step_t         request_plan[$];
    pnorm_pkg::result_t owed_results[$];
    int                 mismatch_count = 0;

    // Shadow copy of the normalizer.
    logic [pnorm_pkg::BYTE_W-1:0] norm_store [PATH_CAP];
    logic [pnorm_pkg::OLEN_W-1:0] slash_pos [STACK_DEPTH];
    logic [11:0]                  depth;
    logic [pnorm_pkg::OLEN_W-1:0] norm_len;
    logic [pnorm_pkg::OLEN_W-1:0] seg_len;
    logic [15:0]                  seg_head;
    logic [pnorm_pkg::OLEN_W-1:0] src_count;
    logic [pnorm_pkg::CFG_W-1:0]  capacity;
    pnorm_pkg::phase_t            path_phase;
    logic                         too_long;
    logic                         relative;
    logic                         terminated;

    function automatic void clear_path_state();
        depth      = '0;
        norm_len   = '0;
        seg_len    = '0;
        seg_head   = '0;
        src_count  = '0;
        too_long   = 1'b0;
        relative   = 1'b0;
        terminated = 1'b0;
    endfunction

    function automatic void put_norm_byte(int unsigned pos, logic [pnorm_pkg::BYTE_W-1:0] b);
        if (pos < PATH_CAP)
            norm_store[pos] = b;
    endfunction

    // Closes the open segment: drops empty and dot segments, pops on dot-dot.
    function automatic void settle_segment();
        logic [pnorm_pkg::OLEN_W-1:0] n;
        logic [pnorm_pkg::BYTE_W-1:0] b0;
        logic [pnorm_pkg::BYTE_W-1:0] b1;
        n  = seg_len;
        b0 = seg_head[7:0];
        b1 = seg_head[15:8];
        seg_len  = '0;
        seg_head = '0;
        if (n == 0)
            return;
        if (n == 1 && b0 == pnorm_pkg::CHAR_DOT)
            return;
        if (n == 2 && b0 == pnorm_pkg::CHAR_DOT && b1 == pnorm_pkg::CHAR_DOT)
        begin
            if (depth != 0)
            begin
                depth    = depth - 1'b1;
                norm_len = slash_pos[depth];
            end
            return;
        end
        if (depth < STACK_DEPTH)
        begin
            slash_pos[depth] = norm_len;
            depth            = depth + 1'b1;
        end
        put_norm_byte(norm_len, pnorm_pkg::CHAR_SLASH);
        norm_len = norm_len + 13'd1 + n;
    endfunction

    function automatic void take_path_byte(logic [pnorm_pkg::BYTE_W-1:0] b);
        if (too_long || terminated)
            return;
        if (b == pnorm_pkg::CHAR_NUL)
        begin
            terminated = 1'b1;
            return;
        end
        src_count = src_count + 1'b1;
        if (src_count >= PATH_CAP)
        begin
            too_long = 1'b1;
            return;
        end
        if (src_count == 1 && b != pnorm_pkg::CHAR_SLASH)
            relative = 1'b1;
        if (relative)
            return;
        if (b == pnorm_pkg::CHAR_SLASH)
        begin
            settle_segment();
            return;
        end
        put_norm_byte(int'(norm_len) + 1 + int'(seg_len), b);
        if (seg_len == 0)
            seg_head = {8'h00, b};
        else if (seg_len == 1)
            seg_head[15:8] = b;
        seg_len = seg_len + 1'b1;
    endfunction

    function automatic pnorm_pkg::status_code_t finish_path();
        if (capacity == 0)
            return pnorm_pkg::RS_SMALL;
        if (too_long)
            return pnorm_pkg::RS_LONG;
        if (relative || src_count == 0)
            return pnorm_pkg::RS_REL;
        settle_segment();
        if (norm_len == 0)
        begin
            put_norm_byte(0, pnorm_pkg::CHAR_SLASH);
            norm_len = 13'd1;
        end
        put_norm_byte(norm_len, pnorm_pkg::CHAR_NUL);
        if (int'(norm_len) + 1 > int'(capacity))
            return pnorm_pkg::RS_SMALL;
        return pnorm_pkg::RS_OK;
    endfunction

    function automatic pnorm_pkg::result_t normalize_step(pnorm_pkg::cmd_code_t c,
                                                          logic [pnorm_pkg::BYTE_W-1:0] b,
                                                          logic [pnorm_pkg::RIDX_W-1:0] idx);
        pnorm_pkg::result_t r;
        r.status     = pnorm_pkg::RS_ACCEPT;
        r.out_length = '0;
        r.out_byte   = '0;
        case (c)
            pnorm_pkg::CMD_BEGIN:
            begin
                clear_path_state();
                path_phase = pnorm_pkg::PH_COLLECT;
            end
            pnorm_pkg::CMD_BYTE:
            begin
                if (path_phase == pnorm_pkg::PH_COLLECT)
                    take_path_byte(b);
                else
                    r.status = pnorm_pkg::RS_NOTREADY;
            end
            pnorm_pkg::CMD_END:
            begin
                if (path_phase == pnorm_pkg::PH_COLLECT)
                begin
                    r.status = finish_path();
                    if (r.status == pnorm_pkg::RS_OK)
                    begin
                        path_phase   = pnorm_pkg::PH_DONE;
                        r.out_length = norm_len + 13'd1;
                    end
                    else
                    begin
                        path_phase = pnorm_pkg::PH_ERROR;
                    end
                end
                else
                begin
                    r.status = pnorm_pkg::RS_NOTREADY;
                end
            end
            default:
            begin
                if (path_phase == pnorm_pkg::PH_DONE)
                begin
                    r.status     = pnorm_pkg::RS_OK;
                    r.out_length = norm_len + 13'd1;
                    if (idx < norm_len)
                        r.out_byte = norm_store[idx];
                end
                else
                begin
                    r.status = pnorm_pkg::RS_NOTREADY;
                end
            end
        endcase
        return r;
    endfunction

    // Idle lengths, with an occasional stretch of back-to-back transfers.
    function automatic int unsigned draw_pause(inout int unsigned calm_left);
        if (calm_left != 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic void plan_request(pnorm_pkg::cmd_code_t c,
                                         logic [pnorm_pkg::BYTE_W-1:0] b,
                                         logic [pnorm_pkg::RIDX_W-1:0] idx);
        plan_step_t s;
        s.kind  = STEP_REQ;
        s.cmd   = c;
        s.pbyte = b;
        s.ridx  = idx;
        s.cap   = '0;
        request_plan.push_back(s);
    endfunction

    function automatic void plan_cmd(pnorm_pkg::cmd_code_t c);
        plan_request(c, pnorm_pkg::BYTE_W'($urandom), pnorm_pkg::RIDX_W'($urandom));
    endfunction

    function automatic void plan_read(logic [pnorm_pkg::RIDX_W-1:0] idx);
        plan_request(pnorm_pkg::CMD_READ, pnorm_pkg::BYTE_W'($urandom), idx);
    endfunction

    function automatic void plan_text(string s);
        foreach (s[i])
            plan_request(pnorm_pkg::CMD_BYTE, s[i], pnorm_pkg::RIDX_W'($urandom));
    endfunction

    function automatic void plan_drain();
        plan_step_t s;
        s.kind  = STEP_DRAIN;
        s.cmd   = pnorm_pkg::CMD_BEGIN;
        s.pbyte = '0;
        s.ridx  = '0;
        s.cap   = '0;
        request_plan.push_back(s);
    endfunction

    // The capacity register is only written once the block has gone quiet.
    function automatic void plan_capacity(logic [pnorm_pkg::CFG_W-1:0] v);
        plan_step_t s;
        plan_drain();
        s.kind  = STEP_CFG;
        s.cmd   = pnorm_pkg::CMD_BEGIN;
        s.pbyte = '0;
        s.ridx  = '0;
        s.cap   = v;
        request_plan.push_back(s);
    endfunction

    // Any byte that is neither NUL nor a slash.
    function automatic logic [pnorm_pkg::BYTE_W-1:0] name_byte();
        logic [pnorm_pkg::BYTE_W-1:0] b;
        b = pnorm_pkg::BYTE_W'($urandom_range(1, 254));
        if (b >= pnorm_pkg::CHAR_SLASH)
            b = b + 1'b1;
        return b;
    endfunction

    function automatic logic [pnorm_pkg::CFG_W-1:0] random_capacity();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return pnorm_pkg::CFG_W'($urandom_range(1, 3));
            2:       return pnorm_pkg::CFG_W'($urandom_range(4, 24));
            3:       return pnorm_pkg::CFG_W'($urandom_range(25, 4096));
            default: return pnorm_pkg::MAX_OUT_LEN_RESET;
        endcase
    endfunction

    // One begin/bytes/end sequence, at times with a second end, followed by reads; returns the requests planned.
    function automatic int unsigned plan_random_path();
        logic [pnorm_pkg::BYTE_W-1:0] text[$];
        int unsigned                  nseg;
        int unsigned                  n;
        int unsigned                  nread;
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(0, 4);
            repeat (n)
                text.push_back(name_byte());
        end
        else
        begin
            text.push_back(pnorm_pkg::CHAR_SLASH);
            nseg = $urandom_range(0, 6);
            for (int s = 0; s < nseg; s++)
            begin
                case ($urandom_range(0, 9))
                    0: ;
                    1: text.push_back(pnorm_pkg::CHAR_DOT);
                    2, 3:
                    begin
                        text.push_back(pnorm_pkg::CHAR_DOT);
                        text.push_back(pnorm_pkg::CHAR_DOT);
                    end
                    4:
                    begin
                        repeat (3)
                            text.push_back(pnorm_pkg::CHAR_DOT);
                    end
                    5:
                    begin
                        text.push_back(pnorm_pkg::CHAR_DOT);
                        text.push_back(name_byte());
                    end
                    default:
                    begin
                        n = $urandom_range(1, 5);
                        repeat (n)
                            text.push_back(name_byte());
                    end
                endcase
                if (s != nseg - 1 || $urandom_range(0, 1) == 1)
                    text.push_back(pnorm_pkg::CHAR_SLASH);
            end
        end
        if ($urandom_range(0, 11) == 0)
            text.insert($urandom_range(0, text.size()), pnorm_pkg::CHAR_NUL);
        plan_cmd(pnorm_pkg::CMD_BEGIN);
        foreach (text[i])
            plan_request(pnorm_pkg::CMD_BYTE, text[i], pnorm_pkg::RIDX_W'($urandom));
        plan_cmd(pnorm_pkg::CMD_END);
        n = text.size() + 2;
        if ($urandom_range(0, 14) == 0)
        begin
            plan_cmd(pnorm_pkg::CMD_END);
            n++;
        end
        nread = $urandom_range(0, 4);
        repeat (nread)
        begin
            if ($urandom_range(0, 4) == 0)
                plan_read(pnorm_pkg::RIDX_W'($urandom));
            else
                plan_read(pnorm_pkg::RIDX_W'($urandom_range(0, text.size() + 1)));
        end
        return n + nread;
    endfunction

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Request driver: one request, register write or drain wait at a time.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        plan_step_t                   step;
        logic                         nx_valid;
        pnorm_pkg::cmd_code_t         nx_cmd;
        logic [pnorm_pkg::BYTE_W-1:0] nx_byte;
        logic [pnorm_pkg::RIDX_W-1:0] nx_index;
        logic                         nx_we;
        logic [pnorm_pkg::CFG_W-1:0]  nx_wdata;
        static int unsigned           gap_left  = 0;
        static int unsigned           calm_left = 0;
        static int unsigned           settle    = 0;
        if (!rst_n)
        begin
            clear_path_state();
            path_phase = pnorm_pkg::PH_IDLE;
            capacity   = pnorm_pkg::MAX_OUT_LEN_RESET;
            req_valid <= 1'b0;
            cfg_we    <= 1'b0;
        end
        else
        begin
            nx_valid = req_valid;
            nx_cmd   = req_cmd;
            nx_byte  = req_byte;
            nx_index = req_index;
            nx_we    = 1'b0;
            nx_wdata = cfg_wdata;
            if (req_valid && req_ch.ready)
            begin
                owed_results.push_back(normalize_step(req_cmd, req_byte, req_index));
                nx_valid = 1'b0;
            end
            if (!nx_valid)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                end
                else if (request_plan.size() != 0)
                begin
                    step = request_plan[0];
                    case (step.kind)
                        STEP_REQ:
                        begin
                            void'(request_plan.pop_front());
                            nx_valid = 1'b1;
                            nx_cmd   = step.cmd;
                            nx_byte  = step.pbyte;
                            nx_index = step.ridx;
                            gap_left = draw_pause(calm_left);
                        end
                        STEP_CFG:
                        begin
                            void'(request_plan.pop_front());
                            nx_we    = 1'b1;
                            nx_wdata = step.cap;
                            capacity = step.cap;
                        end
                        default:
                        begin
                            if (owed_results.size() != 0)
                            begin
                                settle = 0;
                            end
                            else if (settle >= DRAIN_SETTLE)
                            begin
                                void'(request_plan.pop_front());
                                settle = 0;
                            end
                            else
                            begin
                                settle++;
                            end
                        end
                    endcase
                end
            end
            req_valid <= nx_valid;
            req_cmd   <= nx_cmd;
            req_byte  <= nx_byte;
            req_index <= nx_index;
            cfg_we    <= nx_we;
            cfg_wdata <= nx_wdata;
        end
    end

    // Response monitor: random back-pressure, and every response checked in order.
    always @(posedge clk or negedge rst_n)
    begin : response_monitor
        pnorm_pkg::result_t want;
        pnorm_pkg::result_t got;
        logic               nx_ready;
        static int unsigned stall_left = 0;
        static int unsigned calm_left  = 0;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            nx_ready = rsp_ready;
            if (rsp_ch.valid && rsp_ready)
            begin
                got.status     = rsp_ch.status;
                got.out_length = rsp_ch.out_length;
                got.out_byte   = rsp_ch.out_byte;
                if (owed_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: response with none owed: status %0d length %0d byte %02h",
                             $time, got.status, got.out_length, got.out_byte);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        $display("%0t: expected status %0d length %0d byte %02h, got status %0d length %0d byte %02h",
                                 $time, want.status, want.out_length, want.out_byte,
                                 got.status, got.out_length, got.out_byte);
                    end
                end
                stall_left = draw_pause(calm_left);
                nx_ready   = (stall_left == 0);
            end
            else if (!rsp_ready)
            begin
                if (stall_left != 0)
                    stall_left--;
                nx_ready = (stall_left == 0);
            end
            rsp_ready <= nx_ready;
        end
    end

    // Ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin : watchdog
        static int unsigned quiet = 0;
        if (rst_n)
        begin
            if ((req_valid && req_ch.ready) || (rsp_ch.valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("path_normalizer_unit verification failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned random_count;
        int unsigned pick;

        // Requests outside a path are refused.
        plan_cmd(pnorm_pkg::CMD_READ);
        plan_request(pnorm_pkg::CMD_BYTE, 8'hFF, 12'hFFF);
        plan_cmd(pnorm_pkg::CMD_END);

        // Dot, empty and dot-dot segments together.
        plan_cmd(pnorm_pkg::CMD_BEGIN);
        plan_text("/usr/./lib//../bin");
        plan_cmd(pnorm_pkg::CMD_END);
        plan_read(12'd0);
        plan_read(12'd5);
        plan_read(12'd8);
        plan_read(12'hFFF);

        // Climbing above the root leaves the root.
        plan_cmd(pnorm_pkg::CMD_BEGIN);
        plan_text("/../..");
        plan_cmd(pnorm_pkg::CMD_END);
        plan_read(12'd0);

        // Empty path, then a read after the error.
        plan_cmd(pnorm_pkg::CMD_BEGIN);
        plan_cmd(pnorm_pkg::CMD_END);
        plan_cmd(pnorm_pkg::CMD_READ);

        plan_cmd(pnorm_pkg::CMD_BEGIN);
        plan_text("a/b");
        plan_cmd(pnorm_pkg::CMD_END);

        // A NUL byte ends the path early.
        plan_cmd(pnorm_pkg::CMD_BEGIN);
        plan_text("/x");
        plan_request(pnorm_pkg::CMD_BYTE, pnorm_pkg::CHAR_NUL, 12'd0);
        plan_text("/y");
        plan_cmd(pnorm_pkg::CMD_END);
        plan_read(12'd1);

        plan_cmd(pnorm_pkg::CMD_BEGIN);
        plan_request(pnorm_pkg::CMD_BYTE, pnorm_pkg::CHAR_SLASH, 12'hFFF);
        plan_request(pnorm_pkg::CMD_BYTE, 8'hFF, 12'h000);
        plan_request(pnorm_pkg::CMD_BYTE, 8'h80, 12'h000);
        plan_cmd(pnorm_pkg::CMD_END);
        plan_read(12'd1);

        // Zero and tiny capacities.
        plan_capacity(13'd0);
        plan_cmd(pnorm_pkg::CMD_BEGIN);
        plan_text("/");
        plan_cmd(pnorm_pkg::CMD_END);
        plan_capacity(13'd1);
        plan_cmd(pnorm_pkg::CMD_BEGIN);
        plan_text("/");
        plan_cmd(pnorm_pkg::CMD_END);
        plan_capacity(13'd2);
        plan_cmd(pnorm_pkg::CMD_BEGIN);
        plan_text("/");
        plan_cmd(pnorm_pkg::CMD_END);

        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                plan_capacity(random_capacity());
            end
            else if (pick < 8)
            begin
                plan_drain();
            end
            else if (pick < 18)
            begin
                plan_request(pnorm_pkg::cmd_code_t'($urandom_range(0, 3)),
                             pnorm_pkg::BYTE_W'($urandom), pnorm_pkg::RIDX_W'($urandom));
                random_count++;
            end
            else
            begin
                random_count += plan_random_path();
            end
        end

        @(posedge rst_n);
        while (request_plan.size() != 0 || req_valid || owed_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && owed_results.size() == 0)
            $display("path_normalizer_unit verification clean");
        else
            $display("path_normalizer_unit verification failed");
        $finish;
    end

endmodule
